/* rtl/alex_pkg.sv */
package alex_pkg;

  localparam int IndexW = 16;
  localparam int ValueW = 31;
  localparam int CharW  = 8;
  localparam int TypeW  = 3;

  localparam logic [ValueW-1:0] VALUE_MAX = '1;

  localparam logic [CharW-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CharW-1:0] CH_STAR   = 8'h2A;
  localparam logic [CharW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CharW-1:0] CH_LPAREN = 8'h28;
  localparam logic [CharW-1:0] CH_RPAREN = 8'h29;
  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] CH_NINE   = 8'h39;
  localparam logic [CharW-1:0] CH_TAB    = 8'h09;
  localparam logic [CharW-1:0] CH_CR     = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  localparam logic [TypeW-1:0] TOK_NUMBER = 3'd0;
  localparam logic [TypeW-1:0] TOK_PLUS   = 3'd1;
  localparam logic [TypeW-1:0] TOK_MINUS  = 3'd2;
  localparam logic [TypeW-1:0] TOK_STAR   = 3'd3;
  localparam logic [TypeW-1:0] TOK_SLASH  = 3'd4;
  localparam logic [TypeW-1:0] TOK_LPAREN = 3'd5;
  localparam logic [TypeW-1:0] TOK_RPAREN = 3'd6;

  // Number flush slot
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
  } num_slot_t;

  // Operator or error slot
  typedef struct packed {
    kind_t             kind;
    logic [TypeW-1:0]  ttype;
    logic [IndexW-1:0] index;
    logic [CharW-1:0]  bad;
  } main_slot_t;

  // End of expression slot
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              err;
  } end_slot_t;

  // Operator code, TOK_NUMBER when the byte is no operator
  function automatic logic [TypeW-1:0] op_type(input logic [CharW-1:0] c);
    logic [TypeW-1:0] t;
    begin
      unique case (c)
        CH_PLUS:   t = TOK_PLUS;
        CH_MINUS:  t = TOK_MINUS;
        CH_STAR:   t = TOK_STAR;
        CH_SLASH:  t = TOK_SLASH;
        CH_LPAREN: t = TOK_LPAREN;
        CH_RPAREN: t = TOK_RPAREN;
        default:   t = TOK_NUMBER;
      endcase
      return t;
    end
  endfunction

endpackage

/* rtl/arithmetic_expression_lexer.sv */
// An item passes the input register, then the result slots, before its first
// result is shown.
// Throughput: one item per cycle while the result slots are free; an item with
// several results holds the output until the single result port drains them from the three slots.
// Reset (rst, synchronous): position, number state, error flag and all
// valid bits clear at once; no clearing pass.
module arithmetic_expression_lexer
  import alex_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CharW-1:0]    char_code,
  input  logic                end_of_expr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [TypeW-1:0]    token_type,
  output logic [IndexW-1:0]   token_index,
  output logic [ValueW-1:0]   token_value,
  output logic [CharW-1:0]    bad_char,
  output logic                error_seen,
  output logic                last
);

  // Input register
  logic             in_q_valid;
  logic [CharW-1:0] in_q_char;
  logic             in_q_end;

  // Tokeniser state
  logic [IndexW-1:0] position;
  logic              in_number;
  logic [IndexW-1:0] number_start;
  logic [ValueW-1:0] number_value;
  logic              error_flag;

  // Result slots: number flush, operator/error, end
  logic [2:0] slot_v;
  num_slot_t  slot_num;
  main_slot_t slot_main;
  end_slot_t  slot_end;

  logic       out_accept;
  logic       slots_free;
  logic       process;
  logic [2:0] slot_v_left;

  assign out_valid   = |slot_v;
  assign out_accept  = out_valid && !out_stall;
  assign slot_v_left = slot_v & (slot_v - 3'd1);
  assign slots_free  = (slot_v == 3'd0) || (out_accept && (slot_v_left == 3'd0));
  assign process     = in_q_valid && slots_free;
  assign in_stall    = in_q_valid && !process;

  // Decode of the held item
  logic              is_digit;
  logic              is_ws;
  logic [TypeW-1:0]  op;
  logic [3:0]        digit;
  logic [ValueW-1:0] base_value;
  logic [ValueW+3:0] mac;
  logic [ValueW-1:0] acc_value;
  logic [IndexW-1:0] pos_inc;
  logic [IndexW-1:0] start_now;
  logic              num_v_next;
  logic              main_v_next;
  logic              end_v_next;
  logic              err_next;
  num_slot_t         slot_num_next;
  main_slot_t        slot_main_next;
  end_slot_t         slot_end_next;

  always_comb begin
    is_digit   = (in_q_char >= CH_ZERO) && (in_q_char <= CH_NINE);
    is_ws      = ((in_q_char >= CH_TAB) && (in_q_char <= CH_CR)) || (in_q_char == CH_SPACE);
    op         = op_type(in_q_char);
    digit      = in_q_char[3:0];
    base_value = in_number ? number_value : '0;
    // value*10 + digit, saturate when any bit above the 31-bit range is set
    mac        = {1'b0, base_value, 3'b000} + {3'b000, base_value, 1'b0}
               + {{ValueW{1'b0}}, digit};
    acc_value  = (|mac[ValueW+3:ValueW]) ? VALUE_MAX : mac[ValueW-1:0];
    pos_inc    = position + IndexW'(1);
    start_now  = in_number ? number_start : position;

    num_v_next  = !error_flag && ((!is_digit && in_number) || (is_digit && in_q_end));
    main_v_next = !error_flag && !is_digit && ((op != TOK_NUMBER) || !is_ws);
    err_next    = error_flag || (main_v_next && (op == TOK_NUMBER));
    end_v_next  = in_q_end;

    slot_num_next.index = is_digit ? start_now : number_start;
    slot_num_next.value = is_digit ? acc_value : number_value;

    slot_main_next.kind  = (op != TOK_NUMBER) ? KIND_TOKEN : KIND_ERROR;
    slot_main_next.ttype = op;
    slot_main_next.index = position;
    slot_main_next.bad   = (op != TOK_NUMBER) ? '0 : in_q_char;

    slot_end_next.index = pos_inc;
    slot_end_next.err   = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid   <= 1'b0;
      slot_v       <= 3'b000;
      position     <= '0;
      in_number    <= 1'b0;
      number_start <= '0;
      number_value <= '0;
      error_flag   <= 1'b0;
    end else begin
      if (!in_q_valid || process) begin
        in_q_valid <= in_valid;
      end
      if (process) begin
        slot_v <= {end_v_next, main_v_next, num_v_next};
        if (in_q_end) begin
          // end of expression: back to reset state
          position     <= '0;
          in_number    <= 1'b0;
          number_start <= '0;
          number_value <= '0;
          error_flag   <= 1'b0;
        end else begin
          position <= pos_inc;
          if (!error_flag) begin
            if (is_digit) begin
              in_number    <= 1'b1;
              number_start <= start_now;
              number_value <= acc_value;
            end else begin
              in_number    <= 1'b0;
              number_value <= '0;
              error_flag   <= err_next;
            end
          end
        end
      end else if (out_accept) begin
        slot_v <= slot_v_left;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_q_valid || process) begin
      in_q_char <= char_code;
      in_q_end  <= end_of_expr;
    end
    if (process) begin
      slot_num  <= slot_num_next;
      slot_main <= slot_main_next;
      slot_end  <= slot_end_next;
    end
  end

  // Present the earliest pending slot
  always_comb begin
    kind        = KIND_END;
    token_type  = TOK_NUMBER;
    token_index = slot_end.index;
    token_value = '0;
    bad_char    = '0;
    error_seen  = slot_end.err;
    if (slot_v[0]) begin
      kind        = KIND_TOKEN;
      token_index = slot_num.index;
      token_value = slot_num.value;
      error_seen  = 1'b0;
    end else if (slot_v[1]) begin
      kind        = slot_main.kind;
      token_type  = slot_main.ttype;
      token_index = slot_main.index;
      bad_char    = slot_main.bad;
      error_seen  = 1'b0;
    end
    last = (slot_v_left == 3'd0);
  end

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_END)) |-> last)
    else $error("end result not marked last");

  a_error_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (slot_v[1] && (slot_main.kind == KIND_ERROR)) |-> (error_flag || slot_v[2]))
    else $error("error result without error flag");

  a_op_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_TOKEN) && (token_type != TOK_NUMBER)) |-> (token_value == '0))
    else $error("operator token carries a value");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && out_valid && out_stall) |-> in_stall)
    else $error("input taken while result slots are blocked");
`endif

endmodule

/* sim/arithmetic_expression_lexer_test.sv */
`timescale 1ns / 1ps

module arithmetic_expression_lexer_test;
  import alex_pkg::*;

  typedef struct {
    logic [CharW-1:0] code;
    logic             eoe;
  } text_byte_t;

  typedef struct {
    kind_t             kind;
    logic [TypeW-1:0]  ttype;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
    logic [CharW-1:0]  bad;
    logic              err;
    logic              last;
  } lex_result_t;

  localparam int QuietFrom   = 500;
  localparam int QuietTo     = 700;
  localparam int HoldAt      = 250;
  localparam int HoldLen     = 60;
  localparam int StallLimit  = 1000;
  localparam int RandomItems = 450;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CharW-1:0]  char_code = '0;
  logic              end_of_expr = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        kind;
  logic [TypeW-1:0]  token_type;
  logic [IndexW-1:0] token_index;
  logic [ValueW-1:0] token_value;
  logic [CharW-1:0]  bad_char;
  logic              error_seen;
  logic              last;

  text_byte_t  text_bytes[$];
  lex_result_t expected_tokens[$];
  lex_result_t step_results[$];
  logic [CharW-1:0] expr_chars[$];

  int cyc = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  // Tokenizer state as the block should hold it
  logic [IndexW-1:0] lex_pos = '0;
  logic              lex_in_num = 1'b0;
  logic [IndexW-1:0] lex_num_start = '0;
  logic [ValueW-1:0] lex_num_val = '0;
  logic              lex_err = 1'b0;

  arithmetic_expression_lexer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .end_of_expr(end_of_expr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .token_type (token_type),
    .token_index(token_index),
    .token_value(token_value),
    .bad_char   (bad_char),
    .error_seen (error_seen),
    .last       (last)
  );

  initial forever #1 clk = ~clk;

  function automatic lex_result_t make_result(kind_t k, logic [TypeW-1:0] t,
                                              logic [IndexW-1:0] i, logic [ValueW-1:0] v,
                                              logic [CharW-1:0] b, logic e);
    lex_result_t r;
    r.kind  = k;
    r.ttype = t;
    r.index = i;
    r.value = v;
    r.bad   = b;
    r.err   = e;
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic close_number();
    if (lex_in_num) begin
      step_results.push_back(make_result(KIND_TOKEN, TOK_NUMBER, lex_num_start, lex_num_val,
                                         '0, 1'b0));
      lex_in_num  = 1'b0;
      lex_num_val = '0;
    end
  endtask

  // Work out the results one accepted byte causes and queue them
  task automatic tokenize_char(input logic [CharW-1:0] c, input logic eoe);
    logic [TypeW-1:0] op;
    longint grown;
    int digit;
    lex_result_t tail;
    step_results.delete();
    if (!lex_err) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!lex_in_num) begin
          lex_in_num    = 1'b1;
          lex_num_start = lex_pos;
          lex_num_val   = '0;
        end
        digit = int'(c - CH_ZERO);
        grown = longint'(lex_num_val) * 10 + digit;
        lex_num_val = (grown > longint'(VALUE_MAX)) ? VALUE_MAX : grown[ValueW-1:0];
      end else begin
        case (c)
          CH_PLUS:   op = TOK_PLUS;
          CH_MINUS:  op = TOK_MINUS;
          CH_STAR:   op = TOK_STAR;
          CH_SLASH:  op = TOK_SLASH;
          CH_LPAREN: op = TOK_LPAREN;
          CH_RPAREN: op = TOK_RPAREN;
          default:   op = TOK_NUMBER;
        endcase
        close_number();
        if (op != TOK_NUMBER) begin
          step_results.push_back(make_result(KIND_TOKEN, op, lex_pos, '0, '0, 1'b0));
        end else if (!((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) begin
          step_results.push_back(make_result(KIND_ERROR, TOK_NUMBER, lex_pos, '0, c, 1'b0));
          lex_err = 1'b1;
        end
      end
    end
    lex_pos = lex_pos + 1'b1;
    if (eoe) begin
      if (!lex_err) close_number();
      step_results.push_back(make_result(KIND_END, TOK_NUMBER, lex_pos, '0, '0, lex_err));
      lex_pos       = '0;
      lex_in_num    = 1'b0;
      lex_num_start = '0;
      lex_num_val   = '0;
      lex_err       = 1'b0;
    end
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
    foreach (step_results[i]) expected_tokens.push_back(step_results[i]);
  endtask

  task automatic add_byte(input int c, input bit eoe);
    text_byte_t b;
    b.code = c[CharW-1:0];
    b.eoe  = eoe;
    text_bytes.push_back(b);
  endtask

  task automatic add_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) add_byte(int'(s[i]), close && i == s.len() - 1);
  endtask

  task automatic push_space();
    if ($urandom_range(9) < 3)
      expr_chars.push_back(($urandom_range(5) == 5) ? CH_SPACE
                                                    : CharW'(CH_TAB + $urandom_range(4)));
  endtask

  task automatic push_op();
    case ($urandom_range(3))
      0:       expr_chars.push_back(CH_PLUS);
      1:       expr_chars.push_back(CH_MINUS);
      2:       expr_chars.push_back(CH_STAR);
      default: expr_chars.push_back(CH_SLASH);
    endcase
  endtask

  task automatic push_number();
    int digits;
    digits = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
    repeat (digits) expr_chars.push_back(CharW'(CH_ZERO + $urandom_range(9)));
  endtask

  // Mostly well-formed expressions; some pure noise, some with one byte trashed
  task automatic add_random_expr(output int n);
    int mode;
    expr_chars.delete();
    mode = $urandom_range(99);
    if (mode < 12) begin
      repeat ($urandom_range(1, 8)) expr_chars.push_back(CharW'($urandom_range(255)));
    end else begin
      push_space();
      for (int t = 0; t < $urandom_range(1, 4); t++) begin
        if (t > 0) begin
          push_op();
          push_space();
        end
        if ($urandom_range(4) == 0) begin
          expr_chars.push_back(CH_LPAREN);
          push_number();
          push_space();
          push_op();
          push_number();
          expr_chars.push_back(CH_RPAREN);
        end else begin
          push_number();
        end
        push_space();
      end
      if (mode >= 88)
        expr_chars[$urandom_range(expr_chars.size() - 1)] = CharW'($urandom_range(255));
    end
    foreach (expr_chars[i]) add_byte(int'(expr_chars[i]), i == expr_chars.size() - 1);
    n = expr_chars.size();
  endtask

  function automatic bit take_break();
    if (cyc >= QuietFrom && cyc < QuietTo) return 1'b0;
    return $urandom_range(99) < 17;
  endfunction

  task automatic note_mismatch(input string field, input longint got, input longint want);
    $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cyc, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) cyc <= 0;
    else cyc <= cyc + 1;
  end

  always @(posedge clk) begin : drive_bytes
    text_byte_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tokenize_char(char_code, end_of_expr);
      // hold the payload while stalled
      if (!in_valid || !in_stall) begin
        if (text_bytes.size() > 0 && !take_break()) begin
          nb = text_bytes.pop_front();
          in_valid    <= 1'b1;
          char_code   <= nb.code;
          end_of_expr <= nb.eoe;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    lex_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          note_mismatch("kind of unexpected result", kind, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (kind !== want.kind) note_mismatch("kind", kind, want.kind);
          if (token_type !== want.ttype) note_mismatch("token_type", token_type, want.ttype);
          if (token_index !== want.index) note_mismatch("token_index", token_index, want.index);
          if (token_value !== want.value) note_mismatch("token_value", token_value, want.value);
          if (bad_char !== want.bad) note_mismatch("bad_char", bad_char, want.bad);
          if (error_seen !== want.err) note_mismatch("error_seen", error_seen, want.err);
          if (last !== want.last) note_mismatch("last", last, want.last);
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (cyc == HoldAt) begin
        out_stall <= 1'b1;
        hold_left <= HoldLen - 1;
      end else begin
        out_stall <= take_break();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int sent;
    // every operator, whitespace bytes, then an overflowing number closed by the end flag
    add_text("(1+2)-3*4/5", 1'b0);
    for (int c = CH_TAB; c <= CH_CR; c++) add_byte(c, 1'b0);
    add_byte(CH_SPACE, 1'b0);
    add_text("9999999999", 1'b1);
    // zero byte is an error; what follows is dropped
    add_byte(0, 1'b0);
    add_text("7", 1'b1);
    sent = 0;
    while (sent < RandomItems) begin
      add_random_expr(n);
      sent += n;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (text_bytes.size() > 0 || in_valid || expected_tokens.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
